### design/mfep_pkg.sv
// Package with shared types and codes of the MIDI file event parser.
package mfep_pkg;

  localparam logic [2:0] KIND_CHAN    = 3'd0;
  localparam logic [2:0] KIND_META    = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_SYSEX   = 3'd3;
  localparam logic [2:0] KIND_HEADER  = 3'd4;
  localparam logic [2:0] KIND_TRACK   = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;
  localparam logic [2:0] KIND_PAST    = 3'd7;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_HSIG     = 4'd1;
  localparam logic [3:0] ERR_TSIG     = 4'd2;
  localparam logic [3:0] ERR_VARLEN   = 4'd3;
  localparam logic [3:0] ERR_PASTEND  = 4'd4;
  localparam logic [3:0] ERR_DATA     = 4'd5;
  localparam logic [3:0] ERR_SYSEX    = 4'd6;
  localparam logic [3:0] ERR_LEAD     = 4'd7;
  localparam logic [3:0] ERR_NOSTATUS = 4'd8;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       file_start;
  } mfep_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] event_time;
    logic [7:0]  command;
    logic [3:0]  channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [47:0] packed_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [3:0]  error_code;
  } mfep_out_t;

endpackage

### design/mfep_if.sv
// Valid/ready stream interface for the parser's channels.
interface mfep_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/mfep_core.sv
// Parser state machine: one file byte in, at most one result out per call.
module mfep_core
  import mfep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  mfep_in_t  in_item,
  output logic      res_valid,
  output mfep_out_t res_item
);

  typedef enum logic [4:0] {
    PH_HSIG, PH_HLEN, PH_HWORDS, PH_TSIG, PH_TLEN, PH_DELTA, PH_LEAD,
    PH_DATA1, PH_DATA2, PH_MTYPE, PH_MFIXLEN, PH_MFIXDATA, PH_MLEN,
    PH_PAYLOAD, PH_SKIP, PH_SXLEN, PH_SXDATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fc_r, fc_nxt;
  logic [15:0] tcount_r, tcount_nxt;
  logic [15:0] tseen_r, tseen_nxt;
  logic [31:0] tleft_r, tleft_nxt;
  logic [31:0] rtime_r, rtime_nxt;
  logic [7:0]  rstat_r, rstat_nxt;
  logic [27:0] vacc_r, vacc_nxt;
  logic [27:0] prem_r, prem_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [47:0] val_r, val_nxt;
  logic [6:0]  held_r, held_nxt;
  logic        stop_r, stop_nxt;

  function automatic logic [2:0] fix_cnt(input logic [7:0] t);
    case (t)
      8'h00: fix_cnt = 3'd2;
      8'h20, 8'h21: fix_cnt = 3'd1;
      8'h51: fix_cnt = 3'd3;
      8'h54: fix_cnt = 3'd5;
      8'h58: fix_cnt = 3'd4;
      8'h59: fix_cnt = 3'd2;
      default: fix_cnt = 3'd0;
    endcase
  endfunction

  function automatic logic is_fixed(input logic [7:0] t);
    is_fixed = (t == 8'h00) || (t == 8'h20) || (t == 8'h21) || (t == 8'h2F) ||
               (t == 8'h51) || (t == 8'h54) || (t == 8'h58) || (t == 8'h59);
  endfunction

  function automatic logic [7:0] hsig(input logic [1:0] i);
    case (i)
      2'd0: hsig = 8'h4D;
      2'd1: hsig = 8'h54;
      2'd2: hsig = 8'h68;
      default: hsig = 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] tsig(input logic [1:0] i);
    case (i)
      2'd0: tsig = 8'h4D;
      2'd1: tsig = 8'h54;
      2'd2: tsig = 8'h72;
      default: tsig = 8'h6B;
    endcase
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [27:0] va;
    logic [2:0]  fcv;
    logic [2:0]  cmd;
    logic        vdone, verr, pm;
    phase_t      ph;
    logic [2:0]  fc;
    logic [15:0] tc, ts;
    logic [31:0] tl, rt;
    logic [7:0]  rs, mt;
    logic [27:0] vc, pr;
    logic [47:0] vl;
    logic [6:0]  hd;
    logic        st;
    b = in_item.byte_in;
    ph = phase_r; fc = fc_r; tc = tcount_r; ts = tseen_r; tl = tleft_r;
    rt = rtime_r; rs = rstat_r; vc = vacc_r; pr = prem_r; mt = mtype_r;
    vl = val_r; hd = held_r; st = stop_r;
    if (in_item.file_start) begin
      ph = PH_HSIG; fc = '0; tc = '0; ts = '0; tl = '0; rt = '0; rs = '0;
      vc = '0; pr = '0; mt = '0; vl = '0; hd = '0; st = 1'b0;
    end
    res_valid = 1'b0;
    res_item = '0;
    // Shared varlen step on the current byte.
    va = {vc[20:0], b[6:0]};
    fcv = fc + 3'd1;
    vdone = !b[7];
    verr = b[7] && (fcv >= 3'd4);
    cmd = rs[6:4];
    pm = ((mt >= 8'h01) && (mt <= 8'h07)) || (mt == 8'h7F);

    phase_nxt = ph; fc_nxt = fc; tcount_nxt = tc; tseen_nxt = ts;
    tleft_nxt = tl; rtime_nxt = rt; rstat_nxt = rs; vacc_nxt = vc;
    prem_nxt = pr; mtype_nxt = mt; val_nxt = vl; held_nxt = hd;
    stop_nxt = st;

    if (!st) begin
      unique case (ph)
        PH_HSIG: begin
          if (b != hsig(fc[1:0])) begin
            res_valid = 1'b1; res_item.kind = KIND_ERROR;
            res_item.error_code = ERR_HSIG; stop_nxt = 1'b1;
          end else if (fcv >= 3'd4) begin
            fc_nxt = '0; phase_nxt = PH_HLEN;
          end else fc_nxt = fcv;
        end
        PH_HLEN: begin
          if (fcv >= 3'd4) begin
            fc_nxt = '0; val_nxt = '0; phase_nxt = PH_HWORDS;
          end else fc_nxt = fcv;
        end
        PH_HWORDS: begin
          val_nxt = {vl[39:0], b};
          if (fc == 3'd2 || fc == 3'd3) tcount_nxt = {tc[7:0], b};
          fc_nxt = fcv;
          if (fcv >= 3'd6) begin
            res_valid = 1'b1; res_item.kind = KIND_HEADER;
            res_item.packed_value = {vl[39:0], b};
            fc_nxt = '0; tseen_nxt = '0; phase_nxt = PH_TSIG;
          end
        end
        PH_TSIG: begin
          if (b != tsig(fc[1:0])) begin
            res_valid = 1'b1; res_item.kind = KIND_ERROR;
            res_item.error_code = ERR_TSIG; stop_nxt = 1'b1;
          end else if (fcv >= 3'd4) begin
            fc_nxt = '0;
            if ({1'b0, ts} + 17'd1 > {1'b0, tc}) begin
              res_valid = 1'b1; res_item.kind = KIND_PAST; stop_nxt = 1'b1;
            end else begin
              tseen_nxt = ts + 16'd1; tleft_nxt = '0; phase_nxt = PH_TLEN;
            end
          end else fc_nxt = fcv;
        end
        PH_TLEN: begin
          tleft_nxt = {tl[23:0], b};
          fc_nxt = fcv;
          if (fcv >= 3'd4) begin
            res_valid = 1'b1; res_item.kind = KIND_TRACK;
            res_item.packed_value = {16'd0, tl[23:0], b};
            rtime_nxt = '0; rstat_nxt = '0;
            fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_DELTA;
          end
        end
        default: begin
          if (tl == 32'd0) begin
            res_valid = 1'b1; res_item.kind = KIND_ERROR;
            res_item.error_code = ERR_PASTEND; stop_nxt = 1'b1;
          end else begin
            tleft_nxt = tl - 32'd1;
            res_item.event_time = rt;
            case (ph)
              PH_DELTA, PH_MLEN, PH_SXLEN: begin
                vacc_nxt = va; fc_nxt = fcv;
                if (verr) begin
                  res_valid = 1'b1; res_item = '0; res_item.kind = KIND_ERROR;
                  res_item.error_code = ERR_VARLEN; stop_nxt = 1'b1;
                end else if (vdone) begin
                  if (ph == PH_DELTA) begin
                    rtime_nxt = rt + {4'd0, va}; phase_nxt = PH_LEAD;
                  end else if (ph == PH_MLEN) begin
                    if (va == 28'd0) begin
                      fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_DELTA;
                      if (pm) begin
                        res_valid = 1'b1; res_item.kind = KIND_META;
                        res_item.command = mt; val_nxt = '0;
                        if (mt == 8'h2F) phase_nxt = PH_TSIG;
                      end
                    end else begin
                      prem_nxt = va;
                      phase_nxt = pm ? PH_PAYLOAD : PH_SKIP;
                    end
                  end else begin
                    if (va == 28'd0) begin
                      res_valid = 1'b1; res_item = '0; res_item.kind = KIND_ERROR;
                      res_item.error_code = ERR_SYSEX; stop_nxt = 1'b1;
                    end else begin
                      prem_nxt = va; phase_nxt = PH_SXDATA;
                    end
                  end
                end
              end
              PH_LEAD: begin
                if (!b[7]) begin
                  if (rs == 8'd0) begin
                    res_valid = 1'b1; res_item = '0; res_item.kind = KIND_ERROR;
                    res_item.error_code = ERR_NOSTATUS; stop_nxt = 1'b1;
                  end else begin
                    held_nxt = b[6:0];
                    if (cmd == 3'd4 || cmd == 3'd5) begin
                      res_valid = 1'b1; res_item.kind = KIND_CHAN;
                      res_item.command = {5'd0, cmd};
                      res_item.channel = rs[3:0]; res_item.data_first = b[6:0];
                      fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_DELTA;
                    end else phase_nxt = PH_DATA2;
                  end
                end else if (b < 8'hF0) begin
                  rstat_nxt = b; phase_nxt = PH_DATA1;
                end else if (b == 8'hFF) begin
                  phase_nxt = PH_MTYPE;
                end else if (b == 8'hF0) begin
                  fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_SXLEN;
                end else begin
                  res_valid = 1'b1; res_item = '0; res_item.kind = KIND_ERROR;
                  res_item.error_code = ERR_LEAD; stop_nxt = 1'b1;
                end
              end
              PH_DATA1, PH_DATA2: begin
                if (b[7]) begin
                  res_valid = 1'b1; res_item = '0; res_item.kind = KIND_ERROR;
                  res_item.error_code = ERR_DATA; stop_nxt = 1'b1;
                end else if (ph == PH_DATA1 && !(cmd == 3'd4 || cmd == 3'd5)) begin
                  held_nxt = b[6:0]; phase_nxt = PH_DATA2;
                end else begin
                  res_valid = 1'b1; res_item.kind = KIND_CHAN;
                  res_item.channel = rs[3:0];
                  if (ph == PH_DATA1) begin
                    held_nxt = b[6:0];
                    res_item.data_first = b[6:0];
                    res_item.command = {5'd0, cmd};
                  end else begin
                    res_item.data_first = hd; res_item.data_second = b[6:0];
                    res_item.command = (cmd == 3'd1 && b[6:0] == 7'd0) ?
                                       8'd0 : {5'd0, cmd};
                  end
                  fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_DELTA;
                end
              end
              PH_MTYPE: begin
                mtype_nxt = b;
                if (is_fixed(b)) phase_nxt = PH_MFIXLEN;
                else begin
                  fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_MLEN;
                end
              end
              PH_MFIXLEN: begin
                val_nxt = '0; fc_nxt = '0;
                if (fix_cnt(mt) == 3'd0) begin
                  res_valid = 1'b1; res_item.kind = KIND_META;
                  res_item.command = mt;
                  if (mt == 8'h2F) phase_nxt = PH_TSIG;
                  else phase_nxt = PH_DELTA;
                  vacc_nxt = (mt == 8'h2F) ? vc : 28'd0;
                end else phase_nxt = PH_MFIXDATA;
              end
              PH_MFIXDATA: begin
                val_nxt = {vl[39:0], b}; fc_nxt = fcv;
                if (fcv >= fix_cnt(mt)) begin
                  res_valid = 1'b1; res_item.kind = KIND_META;
                  res_item.command = mt; res_item.packed_value = {vl[39:0], b};
                  fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_DELTA;
                end
              end
              PH_PAYLOAD, PH_SKIP: begin
                if (ph == PH_PAYLOAD) begin
                  res_valid = 1'b1; res_item.kind = KIND_PAYLOAD;
                  res_item.command = mt; res_item.payload_byte = b;
                  res_item.payload_last = (pr <= 28'd1);
                end
                if (pr <= 28'd1) begin
                  fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_DELTA;
                end else prem_nxt = pr - 28'd1;
              end
              PH_SXDATA: begin
                if (pr <= 28'd1) begin
                  if (b == 8'hF7) begin
                    res_valid = 1'b1; res_item.kind = KIND_SYSEX;
                    res_item.command = 8'hF0; res_item.payload_byte = 8'hF7;
                    res_item.payload_last = 1'b1;
                    fc_nxt = '0; vacc_nxt = '0; phase_nxt = PH_DELTA;
                  end else begin
                    res_valid = 1'b1; res_item = '0; res_item.kind = KIND_ERROR;
                    res_item.error_code = ERR_SYSEX; stop_nxt = 1'b1;
                  end
                end else begin
                  res_valid = 1'b1; res_item.kind = KIND_PAYLOAD;
                  res_item.command = 8'hF0; res_item.payload_byte = b;
                  prem_nxt = pr - 28'd1;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end
    if (res_item.kind == KIND_CHAN || res_item.kind == KIND_META ||
        res_item.kind == KIND_PAYLOAD || res_item.kind == KIND_SYSEX)
      res_item.event_time = rt;
    else
      res_item.event_time = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HSIG; fc_r <= '0; tcount_r <= '0; tseen_r <= '0;
      tleft_r <= '0; rtime_r <= '0; rstat_r <= '0; vacc_r <= '0;
      prem_r <= '0; mtype_r <= '0; val_r <= '0; held_r <= '0; stop_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; fc_r <= fc_nxt; tcount_r <= tcount_nxt;
      tseen_r <= tseen_nxt; tleft_r <= tleft_nxt; rtime_r <= rtime_nxt;
      rstat_r <= rstat_nxt; vacc_r <= vacc_nxt; prem_r <= prem_nxt;
      mtype_r <= mtype_nxt; val_r <= val_nxt; held_r <= held_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

### design/midi_file_event_parser_unit.sv
// Top level of the MIDI file event parser: input register, parser, result register.
//
//   channel | dir | payload                          | handshake
//   in_     | in  | byte_in, file_start              | valid/ready
//   out_    | out | kind .. error_code (mfep_out_t)  | valid/ready
//
// The parser takes one byte per cycle while the result register is not stalled.
// A request is registered in the input register, parsed by the core when the
// parser stage advances, and its result (if any) is written into the result
// register, from which the out_ channel offers it.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// at the first header signature byte.
// A stalled result holds the parser stage; the input register still takes a
// request while it is empty or moving on.
module midi_file_event_parser_unit
  import mfep_pkg::*;
(
  input logic clk,
  input logic rst_n,
  mfep_if.sink   in_ch,
  mfep_if.source out_ch
);

  mfep_in_t  in_r;
  logic      in_v_r;
  mfep_out_t out_r;
  logic      out_v_r;
  logic      res_valid;
  mfep_out_t res_item;
  logic      step;

  // The parser stage advances when the result register can take its result.
  assign step = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || step;

  mfep_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .in_item  (in_r),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (step) out_v_r <= res_valid;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
    if (in_ch.ready && in_ch.valid) in_r <= in_ch.data;
    if (step && res_valid) out_r <= res_item;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

### design/mfep_checker.sv
// Port checker for the MIDI file event parser, bound to the top level.
module mfep_checker
  import mfep_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input mfep_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_ERROR |-> out_data.error_code == ERR_NONE)
    else $error("error code on non-error result");

  a_err_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERROR |-> out_data.error_code != ERR_NONE)
    else $error("error result without code");

  a_ready_after_rst: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind midi_file_event_parser_unit mfep_checker u_mfep_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);

### dv/midi_file_event_parser_unit_test.sv
// Self-checking testbench for the MIDI file event parser: byte stream in, parsed events out.
module midi_file_event_parser_unit_test
  import mfep_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Parse phases of the predictor.
  typedef enum int {
    P_HSIG, P_HLEN, P_HWORDS, P_TSIG, P_TLEN, P_DELTA, P_LEAD, P_DATA1, P_DATA2,
    P_MTYPE, P_MFIXLEN, P_MFIXDATA, P_MLEN, P_PAYLOAD, P_SKIP, P_SXLEN, P_SXDATA
  } phase_t;

  localparam logic [7:0] ST_META  = 8'hFF;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_EOX   = 8'hF7;
  localparam logic [7:0] MT_EOT   = 8'h2F;
  localparam logic [7:0] MT_TEMPO = 8'h51;
  localparam logic [7:0] MT_SEQSP = 8'h7F;
  localparam int LIMIT_CYCLES = 400000;

  // The scoreboard keeps its own copy of the parser state and the queue of
  // events that the block still owes.
  class midi_event_scoreboard;
    phase_t      ph;
    logic [2:0]  cnt;
    logic [15:0] ntracks, tseen;
    logic [31:0] tleft, rtime;
    logic [7:0]  rstat, mtype;
    logic [27:0] vacc, prem;
    logic [47:0] valacc;
    logic [6:0]  held;
    bit          stopped;
    mfep_out_t   pending_events[$];
    int          errors;
    mfep_out_t   r;
    bit          got;

    function void clear();
      ph = P_HSIG; cnt = 0; ntracks = 0; tseen = 0; tleft = 0; rtime = 0;
      rstat = 0; mtype = 0; vacc = 0; prem = 0; valacc = 0; held = 0; stopped = 0;
    endfunction

    function int fixed_len(logic [7:0] t);
      case (t)
        8'h00: return 2;
        8'h20, 8'h21: return 1;
        MT_EOT: return 0;
        MT_TEMPO: return 3;
        8'h54: return 5;
        8'h58: return 4;
        8'h59: return 2;
        default: return -1;
      endcase
    endfunction

    function bit is_text(logic [7:0] t);
      return (t >= 8'h01 && t <= 8'h07) || t == MT_SEQSP;
    endfunction

    function void raise(logic [3:0] code);
      r = '0; r.kind = KIND_ERROR; r.error_code = code; got = 1; stopped = 1;
    endfunction

    function void emit(logic [2:0] k, logic [7:0] c);
      got = 1; r.kind = k; r.event_time = rtime; r.command = c;
    endfunction

    function void restart_delta(phase_t p);
      cnt = 0; vacc = 0; ph = p;
    endfunction

    // 1 = complete, 0 = more bytes, -1 = too long (error raised)
    function int take_varlen(logic [7:0] b);
      vacc = {vacc[20:0], b[6:0]};
      cnt = cnt + 1;
      if (!b[7]) return 1;
      if (cnt >= 4) begin
        raise(ERR_VARLEN);
        return -1;
      end
      return 0;
    endfunction

    function void finish_meta();
      emit(KIND_META, mtype);
      r.packed_value = valacc;
      if (mtype == MT_EOT) begin
        cnt = 0; ph = P_TSIG;
      end else begin
        restart_delta(P_DELTA);
      end
    endfunction

    function void channel_event(logic [6:0] d1, logic [6:0] d2);
      logic [7:0] c;
      c = {5'd0, rstat[6:4]};
      if (c == 1 && d2 == 0) c = 0;
      emit(KIND_CHAN, c);
      r.channel = rstat[3:0]; r.data_first = d1; r.data_second = d2;
      restart_delta(P_DELTA);
    endfunction

    function void first_data(logic [7:0] b);
      held = b[6:0];
      if (rstat[6:4] == 4 || rstat[6:4] == 5) channel_event(b[6:0], 0);
      else ph = P_DATA2;
    endfunction

    function void body(logic [7:0] b);
      int v;
      case (ph)
        P_DELTA: if (take_varlen(b) == 1) begin
          rtime = rtime + vacc; ph = P_LEAD;
        end
        P_LEAD: begin
          if (b < 8'h80) begin
            if (rstat == 0) raise(ERR_NOSTATUS);
            else first_data(b);
          end else if (b < 8'hF0) begin
            rstat = b; ph = P_DATA1;
          end else if (b == ST_META) ph = P_MTYPE;
          else if (b == ST_SYSEX) restart_delta(P_SXLEN);
          else raise(ERR_LEAD);
        end
        P_DATA1: if (b[7]) raise(ERR_DATA); else first_data(b);
        P_DATA2: if (b[7]) raise(ERR_DATA); else channel_event(held, b[6:0]);
        P_MTYPE: begin
          mtype = b;
          if (fixed_len(b) >= 0) ph = P_MFIXLEN;
          else restart_delta(P_MLEN);
        end
        P_MFIXLEN: begin
          valacc = 0; cnt = 0;
          if (fixed_len(mtype) <= 0) finish_meta();
          else ph = P_MFIXDATA;
        end
        P_MFIXDATA: begin
          valacc = {valacc[39:0], b};
          cnt = cnt + 1;
          if (int'(cnt) >= fixed_len(mtype)) finish_meta();
        end
        P_MLEN: begin
          v = take_varlen(b);
          if (v == 1) begin
            if (vacc == 0) begin
              if (is_text(mtype)) begin
                valacc = 0; finish_meta();
              end else restart_delta(P_DELTA);
            end else begin
              prem = vacc; ph = is_text(mtype) ? P_PAYLOAD : P_SKIP;
            end
          end
        end
        P_PAYLOAD: begin
          emit(KIND_PAYLOAD, mtype);
          r.payload_byte = b; r.payload_last = prem <= 1;
          if (prem <= 1) restart_delta(P_DELTA); else prem = prem - 1;
        end
        P_SKIP: if (prem <= 1) restart_delta(P_DELTA); else prem = prem - 1;
        P_SXLEN: begin
          v = take_varlen(b);
          if (v == 1) begin
            if (vacc == 0) raise(ERR_SYSEX);
            else begin
              prem = vacc; ph = P_SXDATA;
            end
          end
        end
        P_SXDATA: begin
          if (prem <= 1) begin
            if (b == ST_EOX) begin
              emit(KIND_SYSEX, ST_SYSEX);
              r.payload_byte = ST_EOX; r.payload_last = 1;
              restart_delta(P_DELTA);
            end else raise(ERR_SYSEX);
          end else begin
            emit(KIND_PAYLOAD, ST_SYSEX); r.payload_byte = b; prem = prem - 1;
          end
        end
        default: ;
      endcase
    endfunction

    // Notes one accepted request and queues the event it causes, if any.
    function void note_request(mfep_in_t req);
      logic [7:0] b;
      b = req.byte_in;
      r = '0; got = 0;
      if (req.file_start) clear();
      if (stopped) return;
      case (ph)
        P_HSIG: begin
          if (b != hdr_byte(cnt[1:0])) raise(ERR_HSIG);
          else begin
            cnt = cnt + 1;
            if (cnt >= 4) begin
              cnt = 0; ph = P_HLEN;
            end
          end
        end
        P_HLEN: begin
          cnt = cnt + 1;
          if (cnt >= 4) begin
            cnt = 0; valacc = 0; ph = P_HWORDS;
          end
        end
        P_HWORDS: begin
          valacc = {valacc[39:0], b};
          if (cnt == 2 || cnt == 3) ntracks = {ntracks[7:0], b};
          cnt = cnt + 1;
          if (cnt >= 6) begin
            got = 1; r.kind = KIND_HEADER; r.packed_value = valacc;
            cnt = 0; tseen = 0; ph = P_TSIG;
          end
        end
        P_TSIG: begin
          if (b != trk_byte(cnt[1:0])) raise(ERR_TSIG);
          else begin
            cnt = cnt + 1;
            if (cnt >= 4) begin
              cnt = 0;
              if (32'(tseen) + 1 > 32'(ntracks)) begin
                got = 1; r.kind = KIND_PAST; stopped = 1;
              end else begin
                tseen = tseen + 1; tleft = 0; ph = P_TLEN;
              end
            end
          end
        end
        P_TLEN: begin
          tleft = {tleft[23:0], b};
          cnt = cnt + 1;
          if (cnt >= 4) begin
            got = 1; r.kind = KIND_TRACK; r.packed_value = {16'd0, tleft};
            rtime = 0; rstat = 0; restart_delta(P_DELTA);
          end
        end
        default: begin
          if (tleft == 0) raise(ERR_PASTEND);
          else begin
            tleft = tleft - 1; body(b);
          end
        end
      endcase
      if (got) pending_events.push_back(r);
    endfunction

    function logic [7:0] hdr_byte(logic [1:0] i);
      logic [7:0] s[4] = '{8'h4D, 8'h54, 8'h68, 8'h64};
      return s[i];
    endfunction

    function logic [7:0] trk_byte(logic [1:0] i);
      logic [7:0] s[4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};
      return s[i];
    endfunction

    // Compares one accepted event against the oldest one owed.
    function void check_event(mfep_out_t got_ev);
      mfep_out_t e;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, actual %p", $realtime, got_ev);
        errors++;
        return;
      end
      e = pending_events.pop_front();
      if (got_ev.kind != e.kind) report("kind", e.kind, got_ev.kind);
      if (got_ev.event_time != e.event_time)
        report("event_time", e.event_time, got_ev.event_time);
      if (got_ev.command != e.command) report("command", e.command, got_ev.command);
      if (got_ev.channel != e.channel) report("channel", e.channel, got_ev.channel);
      if (got_ev.data_first != e.data_first)
        report("data_first", e.data_first, got_ev.data_first);
      if (got_ev.data_second != e.data_second)
        report("data_second", e.data_second, got_ev.data_second);
      if (got_ev.packed_value != e.packed_value)
        report("packed_value", e.packed_value, got_ev.packed_value);
      if (got_ev.payload_byte != e.payload_byte)
        report("payload_byte", e.payload_byte, got_ev.payload_byte);
      if (got_ev.payload_last != e.payload_last)
        report("payload_last", e.payload_last, got_ev.payload_last);
      if (got_ev.error_code != e.error_code)
        report("error_code", e.error_code, got_ev.error_code);
    endfunction

    function void report(string f, logic [63:0] e, logic [63:0] a);
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $realtime, f, e, a);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #10 clk = ~clk;

  mfep_if #(mfep_in_t)  in_ch (clk);
  mfep_if #(mfep_out_t) out_ch (clk);

  midi_file_event_parser_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  midi_event_scoreboard sb = new();
  int cycles = 0;
  bit stim_done = 0;

  // The sink side: random stalls, mostly short, now and then long, with
  // quiet stretches where ready simply stays high.
  initial begin
    int gap;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        out_ch.ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1;
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end
  end

  // Results are taken at the rising edge on which the handshake completes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_event(out_ch.data);
  end

  // The stream of bytes that the next file is made of.
  logic [7:0] file_bytes[$];
  bit burst_mode;
  int bytes_sent = 0;

  // Sends one byte; file_start goes with the first byte of a file.
  task automatic send_byte(logic [7:0] b, bit first);
    int gap;
    if (!burst_mode && $urandom_range(0, 4) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2);
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data.byte_in = b;
    in_ch.data.file_start = first;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(in_ch.data);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    int n;
    n = file_bytes.size();
    burst_mode = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == 0);
    file_bytes.delete();
  endtask

  // Track bytes are gathered apart so their length can be put in front.
  logic [7:0] trk[$];

  task automatic put_varlen(int unsigned v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--)
      trk.push_back({(i != 0), 7'(v >> (7 * i))});
  endtask

  task automatic add_header(logic [15:0] fmt, logic [15:0] ntr, logic [15:0] div);
    file_bytes.push_back(8'h4D); file_bytes.push_back(8'h54);
    file_bytes.push_back(8'h68); file_bytes.push_back(8'h64);
    for (int i = 0; i < 4; i++) file_bytes.push_back(i == 3 ? 8'd6 : 8'd0);
    file_bytes.push_back(fmt[15:8]); file_bytes.push_back(fmt[7:0]);
    file_bytes.push_back(ntr[15:8]); file_bytes.push_back(ntr[7:0]);
    file_bytes.push_back(div[15:8]); file_bytes.push_back(div[7:0]);
  endtask

  // Closes a track: signature, length (true or, now and then, wrong) and body.
  task automatic add_track(int len_adjust);
    int unsigned len;
    len = trk.size() + len_adjust;
    file_bytes.push_back(8'h4D); file_bytes.push_back(8'h54);
    file_bytes.push_back(8'h72); file_bytes.push_back(8'h6B);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(8'(len >> (8 * i)));
    foreach (trk[i]) file_bytes.push_back(trk[i]);
    trk.delete();
  endtask

  function automatic int small_delta();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom_range(1, 127);
      2: return $urandom_range(128, 16383);
      3: return $urandom_range(16384, 2097151);
      default: return $urandom_range(2097152, 28'hFFFFFFF);
    endcase
  endfunction

  function automatic int vl_bytes(int unsigned v);
    return v < 128 ? 1 : v < 16384 ? 2 : v < 2097152 ? 3 : 4;
  endfunction

  // One random event with its delta; a few of them are deliberately broken.
  task automatic add_event(bit allow_bad);
    int unsigned d, n;
    int sel;
    logic [7:0] t;
    d = small_delta();
    put_varlen(d, vl_bytes(d));
    sel = $urandom_range(0, allow_bad ? 12 : 9);
    case (sel)
      0, 1, 2: begin
        // Program change and channel pressure carry a single data byte.
        t = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        trk.push_back(t);
        trk.push_back(8'($urandom_range(0, 127)));
        if (t[6:4] != 3'd4 && t[6:4] != 3'd5)
          trk.push_back($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(0, 127)));
      end
      3: begin
        // Running status: data bytes only; may hit an undefined status.
        trk.push_back(8'($urandom_range(0, 127)));
        trk.push_back(8'($urandom_range(0, 127)));
      end
      4: begin
        t = fixed_meta();
        trk.push_back(ST_META); trk.push_back(t); trk.push_back(8'($urandom));
        for (int i = 0; i < sb.fixed_len(t); i++) trk.push_back(8'($urandom));
      end
      5, 6: begin
        t = $urandom_range(0, 1) ? 8'($urandom_range(1, 7)) : MT_SEQSP;
        n = $urandom_range(0, 4);
        trk.push_back(ST_META); trk.push_back(t); put_varlen(n, vl_bytes(n));
        for (int i = 0; i < n; i++) trk.push_back(8'($urandom));
      end
      7: begin
        t = 8'($urandom_range(8, 8'h1F));
        n = $urandom_range(0, 3);
        trk.push_back(ST_META); trk.push_back(t); put_varlen(n, 2);
        for (int i = 0; i < n; i++) trk.push_back(8'($urandom));
      end
      8, 9: begin
        n = $urandom_range(1, 4);
        trk.push_back(ST_SYSEX); put_varlen(n, vl_bytes(n));
        for (int i = 1; i < n; i++) trk.push_back(8'($urandom));
        trk.push_back(ST_EOX);
      end
      10: trk.push_back(8'($urandom_range(8'hF1, 8'hFE)));
      11: begin
        trk.push_back(8'h90); trk.push_back(8'($urandom_range(128, 255)));
      end
      default: begin
        for (int i = 0; i < 5; i++) trk.push_back(8'($urandom_range(128, 255)));
      end
    endcase
  endtask

  function automatic logic [7:0] fixed_meta();
    logic [7:0] l[7] = '{8'h00, 8'h20, 8'h21, MT_TEMPO, 8'h54, 8'h58, 8'h59};
    return l[$urandom_range(0, 6)];
  endfunction

  // A whole well-formed (or lightly damaged) file with random content.
  task automatic random_file();
    int ntr, nev;
    bit bad;
    bad = ($urandom_range(0, 4) == 0);
    ntr = $urandom_range(1, 2);
    add_header(16'($urandom_range(0, 2)), 16'(ntr), 16'($urandom));
    for (int k = 0; k < ntr + 1; k++) begin
      nev = $urandom_range(1, 6);
      trk.push_back(8'd0); trk.push_back(8'hC3); trk.push_back(8'($urandom_range(0, 127)));
      for (int e = 0; e < nev; e++) add_event(bad);
      trk.push_back(8'd0); trk.push_back(ST_META); trk.push_back(MT_EOT);
      trk.push_back(8'd0);
      add_track((bad && $urandom_range(0, 2) == 0) ? -2 : 0);
    end
    if ($urandom_range(0, 5) == 0) file_bytes[$urandom_range(0, 3)] = 8'($urandom);
    send_file();
  endtask

  task automatic wait_drained();
    while (sb.pending_events.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    bit held_off;
    in_ch.valid = 0;
    in_ch.data = '0;
    burst_mode = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // Directed file: extreme header fields and SMPTE division, note-on, program change,
    // channel pressure and pitch bend, note-on at velocity zero, fixed and text metas,
    // a zero-length text, an unknown meta, a sysex, then a track beyond the stated count.
    add_header(16'hFFFF, 16'd1, 16'hE728);
    put_varlen(28'hFFFFFFF, 4); trk.push_back(8'h9F); trk.push_back(8'h7F);
    trk.push_back(8'h00);
    put_varlen(0, 1); trk.push_back(8'h7F); trk.push_back(8'h7F);
    put_varlen(1, 1); trk.push_back(8'hC0); trk.push_back(8'h55);
    put_varlen(2, 1); trk.push_back(8'hD5); trk.push_back(8'h00);
    put_varlen(3, 1); trk.push_back(8'hE9); trk.push_back(8'h00); trk.push_back(8'h40);
    put_varlen(0, 1); trk.push_back(ST_META); trk.push_back(MT_TEMPO);
    trk.push_back(8'd3); trk.push_back(8'hFF); trk.push_back(8'h00); trk.push_back(8'hAA);
    put_varlen(0, 1); trk.push_back(ST_META); trk.push_back(8'h03); trk.push_back(8'd0);
    put_varlen(0, 1); trk.push_back(ST_META); trk.push_back(8'h45); trk.push_back(8'd1);
    trk.push_back(8'h99);
    put_varlen(0, 1); trk.push_back(ST_SYSEX); trk.push_back(8'd2);
    trk.push_back(8'hFF); trk.push_back(ST_EOX);
    put_varlen(0, 1); trk.push_back(ST_META); trk.push_back(MT_EOT); trk.push_back(8'd0);
    add_track(0);
    file_bytes.push_back(8'h4D); file_bytes.push_back(8'h54);
    file_bytes.push_back(8'h72); file_bytes.push_back(8'h6B);
    file_bytes.push_back(8'h00);
    send_file();
    wait_drained();

    // Short broken files: bad header, zero-length sysex, overlong delta.
    file_bytes.push_back(8'h00); send_file();
    add_header(0, 1, 0); put_varlen(0, 1); trk.push_back(ST_SYSEX); trk.push_back(8'd0);
    add_track(0); send_file();
    add_header(0, 1, 0); for (int i = 0; i < 5; i++) trk.push_back(8'hFF);
    add_track(0); send_file();

    // Random files until enough bytes went in; at one point the sender
    // holds off until the block has caught up.
    held_off = 0;
    while (bytes_sent < 550) begin
      random_file();
      if (!held_off && bytes_sent >= 300) begin
        wait_drained();
        held_off = 1;
      end
    end
    in_ch.valid = 0;
    stim_done = 1;
  end

  // End of run: wait for the owed events, then report the result.
  initial begin
    wait (stim_done);
    while (sb.pending_events.size() != 0 && cycles < LIMIT_CYCLES) @(negedge clk);
    repeat (20) @(negedge clk);
    if (cycles >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
    end else if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    wait (cycles >= LIMIT_CYCLES);
    if (!stim_done) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
endmodule
